// File: hdl/krt_pkg.sv
// shared types, codes and sizes for the keyed record table
package krt_pkg;

	// table size and derived widths
	localparam int DEPTH  = 16;
	localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int NAME_B = 20;

	// request operation codes
	typedef enum logic [2:0] {
		FN_INSERT    = 3'd0,
		FN_DELETE    = 3'd1,
		FN_FIND_ID   = 3'd2,
		FN_FIND_NAME = 3'd3,
		FN_UPDATE    = 3'd4
	} krt_func_e;

	// response status codes
	typedef enum logic [1:0] {
		ST_DONE = 2'd0,
		ST_NONE = 2'd1,
		ST_FULL = 2'd2
	} krt_status_e;

	// sequencer states
	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_SHIFT,
		S_OUT
	} krt_state_e;

	// request beat
	typedef struct packed {
		logic [2:0]  func;
		logic [15:0] student_id;
		logic [63:0] name_word0;
		logic [63:0] name_word1;
		logic [31:0] name_word2;
		logic [15:0] age_value;
		logic [15:0] score_value;
	} krt_req_t;

	// response beat
	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] found_id;
		logic [63:0] found_name0;
		logic [63:0] found_name1;
		logic [31:0] found_name2;
		logic [15:0] found_age;
		logic [15:0] found_score;
	} krt_rsp_t;

	// one stored record
	typedef struct packed {
		logic [15:0] id;
		logic [63:0] name_lo;
		logic [63:0] name_mid;
		logic [31:0] name_hi;
		logic [15:0] age;
		logic [15:0] score;
	} krt_rec_t;

endpackage

// File: hdl/krt_match.sv
// key compare unit: id equality or string compare of the 20-byte name
module krt_match (
	input  krt_pkg::krt_req_t key,
	input  krt_pkg::krt_rec_t entry,
	output logic              hit
);
	import krt_pkg::*;

	logic [NAME_B*8-1:0] name_a;
	logic [NAME_B*8-1:0] name_b;
	logic [NAME_B-1:0]   byte_eq;
	logic [NAME_B-1:0]   both_zero;
	logic [NAME_B-1:0]   ended_before;
	logic                name_hit;

	assign name_a = {entry.name_hi, entry.name_mid, entry.name_lo};
	assign name_b = {key.name_word2, key.name_word1, key.name_word0};

	// per-byte equality and terminator flags
	always_comb begin
		for (int k = 0; k < NAME_B; k++) begin
			byte_eq[k]   = name_a[k*8 +: 8] == name_b[k*8 +: 8];
			both_zero[k] = byte_eq[k] && (name_a[k*8 +: 8] == 8'h00);
		end
	end

	// a byte only matters if no earlier shared terminator ended the string
	always_comb begin
		ended_before[0] = 1'b0;
		for (int k = 1; k < NAME_B; k++) begin
			ended_before[k] = ended_before[k-1] | both_zero[k-1];
		end
	end

	assign name_hit = &(byte_eq | ended_before);

	// choose the compare by operation
	assign hit = (key.func == FN_FIND_NAME) ? name_hit : (entry.id == key.student_id);

endmodule

// File: hdl/keyed_record_table.sv
// Ordered table of up to DEPTH records with insert, delete, find and update by a small
// sequencer around one record memory with a single read port and one compare unit. One
// request is handled at a time: insert and unknown operations go straight to the response
// state, a find or update walks the stored records one per cycle until a hit or the
// end of the table, and a delete adds a compaction pass that moves each later record up
// one place, one per cycle, when a record is removed. A finished response waits in an
// output register, and the next request is taken as soon as the sequencer is idle again.
module keyed_record_table (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  krt_pkg::krt_req_t req,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output krt_pkg::krt_rsp_t rsp
);
	import krt_pkg::*;

	// record memory
	krt_rec_t rec_mem_q [DEPTH];
	krt_rec_t rd_data_q;

	// control state
	krt_state_e       state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [CNT_W-1:0] idx_q, idx_d;
	logic             cmp_v_q, cmp_v_d;
	logic [IDX_W-1:0] cmp_idx_q, cmp_idx_d;
	logic             pend_q, pend_d;
	logic [IDX_W-1:0] pend_idx_q, pend_idx_d;
	logic             rsp_valid_q, rsp_valid_d;

	// payload state
	krt_req_t    req_q;
	krt_rec_t    hit_q;
	krt_status_e status_q, status_d;
	logic        found_q, found_d;
	krt_rsp_t    rsp_q;

	// sequencer controls
	logic             take_req;
	logic             latch_hit;
	logic             load_rsp;
	logic             mem_we;
	logic [IDX_W-1:0] mem_waddr;
	krt_rec_t         mem_wdata;
	logic [IDX_W-1:0] rd_addr;
	logic             hit;
	logic [CNT_W-1:0] idx_dec;

	krt_match u_match (
		.key   (req_q),
		.entry (rd_data_q),
		.hit   (hit)
	);

	assign idx_dec = idx_q - 1'b1;

	// next state and controls
	always_comb begin
		state_d     = state_q;
		cnt_d       = cnt_q;
		idx_d       = idx_q;
		cmp_v_d     = 1'b0;
		cmp_idx_d   = cmp_idx_q;
		pend_d      = pend_q;
		pend_idx_d  = pend_idx_q;
		status_d    = status_q;
		found_d     = found_q;
		take_req    = 1'b0;
		latch_hit   = 1'b0;
		load_rsp    = 1'b0;
		mem_we      = 1'b0;
		mem_waddr   = cnt_q[IDX_W-1:0];
		mem_wdata   = rd_data_q;
		rd_addr     = idx_q[IDX_W-1:0];
		rsp_valid_d = rsp_valid_q && rsp_stall;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					take_req = 1'b1;
					idx_d    = '0;
					pend_d   = 1'b0;
					found_d  = 1'b0;
					if (req.func == FN_INSERT) begin
						if (cnt_q == CNT_W'(DEPTH)) begin
							status_d = ST_FULL;
						end else begin
							mem_we    = 1'b1;
							mem_waddr = cnt_q[IDX_W-1:0];
							mem_wdata = '{id: req.student_id, name_lo: req.name_word0,
								name_mid: req.name_word1, name_hi: req.name_word2,
								age: req.age_value, score: req.score_value};
							cnt_d     = cnt_q + 1'b1;
							status_d  = ST_DONE;
						end
						state_d = S_OUT;
					end else if (req.func == FN_DELETE || req.func == FN_FIND_ID ||
						req.func == FN_FIND_NAME || req.func == FN_UPDATE) begin
						state_d = S_SCAN;
					end else begin
						status_d = ST_NONE;
						state_d  = S_OUT;
					end
				end
			end
			S_SCAN: begin
				if (cmp_v_q && hit) begin
					latch_hit = 1'b1;
					status_d  = ST_DONE;
					if (req_q.func == FN_DELETE) begin
						idx_d   = {1'b0, cmp_idx_q} + 1'b1;
						pend_d  = 1'b0;
						state_d = S_SHIFT;
					end else if (req_q.func == FN_UPDATE) begin
						mem_we          = 1'b1;
						mem_waddr       = cmp_idx_q;
						mem_wdata       = rd_data_q;
						mem_wdata.score = req_q.score_value;
						state_d         = S_OUT;
					end else begin
						found_d = 1'b1;
						state_d = S_OUT;
					end
				end else if (idx_q < cnt_q) begin
					rd_addr   = idx_q[IDX_W-1:0];
					cmp_v_d   = 1'b1;
					cmp_idx_d = idx_q[IDX_W-1:0];
					idx_d     = idx_q + 1'b1;
				end else begin
					status_d = ST_NONE;
					state_d  = S_OUT;
				end
			end
			S_SHIFT: begin
				// write back the record read last cycle one place lower
				if (pend_q) begin
					mem_we    = 1'b1;
					mem_waddr = pend_idx_q;
					mem_wdata = rd_data_q;
				end
				if (idx_q < cnt_q) begin
					rd_addr    = idx_q[IDX_W-1:0];
					pend_d     = 1'b1;
					pend_idx_d = idx_dec[IDX_W-1:0];
					idx_d      = idx_q + 1'b1;
				end else begin
					pend_d = 1'b0;
					if (!pend_q) begin
						cnt_d    = cnt_q - 1'b1;
						status_d = ST_DONE;
						state_d  = S_OUT;
					end
				end
			end
			S_OUT: begin
				if (!rsp_valid_q || !rsp_stall) begin
					load_rsp    = 1'b1;
					rsp_valid_d = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			idx_q       <= '0;
			cmp_v_q     <= 1'b0;
			cmp_idx_q   <= '0;
			pend_q      <= 1'b0;
			pend_idx_q  <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			cnt_q       <= cnt_d;
			idx_q       <= idx_d;
			cmp_v_q     <= cmp_v_d;
			cmp_idx_q   <= cmp_idx_d;
			pend_q      <= pend_d;
			pend_idx_q  <= pend_idx_d;
			rsp_valid_q <= rsp_valid_d;
		end
	end

	// request, hit and status holding
	always_ff @(posedge clk) begin
		status_q <= status_d;
		found_q  <= found_d;
		if (take_req) begin
			req_q <= req;
		end
		if (latch_hit) begin
			hit_q <= rd_data_q;
		end
	end

	// response register
	always_ff @(posedge clk) begin
		if (load_rsp) begin
			rsp_q.status      <= status_q;
			rsp_q.found_id    <= found_q ? hit_q.id : '0;
			rsp_q.found_name0 <= found_q ? hit_q.name_lo : '0;
			rsp_q.found_name1 <= found_q ? hit_q.name_mid : '0;
			rsp_q.found_name2 <= found_q ? hit_q.name_hi : '0;
			rsp_q.found_age   <= found_q ? hit_q.age : '0;
			rsp_q.found_score <= found_q ? hit_q.score : '0;
		end
	end

	// record memory, one write and one registered read a cycle
	always_ff @(posedge clk) begin
		if (mem_we) begin
			rec_mem_q[mem_waddr] <= mem_wdata;
		end
		rd_data_q <= rec_mem_q[rd_addr];
	end

	assign req_stall = state_q != S_IDLE;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// record count never passes the table size
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(DEPTH))
		else $error("record count above table size");

	// a request moves the count by at most one
	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_IDLE ##1 state_q == S_IDLE |->
			cnt_q == $past(cnt_q) || cnt_q == $past(cnt_q) + 1'b1 ||
			cnt_q == $past(cnt_q) - 1'b1)
		else $error("record count jumped");

	// an accepted request always takes the sequencer out of idle
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> state_q != S_IDLE)
		else $error("sequencer stayed idle after a request");

	// a new response only comes from the response state
	a_rsp_source: assert property (@(posedge clk) disable iff (!arst_n)
		load_rsp |-> state_q == S_OUT && (!rsp_valid_q || !rsp_stall))
		else $error("response loaded while slot busy");

	// responses that are not done carry no record id, age or score
	a_rsp_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_q.status != ST_DONE |->
			rsp_q.found_id == '0 && rsp_q.found_age == '0 && rsp_q.found_score == '0)
		else $error("record data on a failed response");

endmodule

// File: tb/tb_top.sv
// self-checking testbench for the keyed record table: directed table, then random traffic
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import krt_pkg::*;

	// request codes with no operation behind them
	localparam logic [2:0] FN_SPARE_LO  = 3'd5;
	localparam logic [2:0] FN_SPARE_MID = 3'd6;
	localparam logic [2:0] FN_SPARE_HI  = 3'd7;

	localparam int PHASE_ITEMS  = 125;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 2 * DEPTH + 10;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int KEY_POOL     = 6;
	localparam int NAME_POOL    = 8;

	// one row of the directed table; reps > 1 repeats it with the id stepping up
	typedef struct {
		krt_req_t req;
		int       reps;
		bit       exact;
		krt_rsp_t want;
	} script_row_t;

	logic     clk       = 1'b0;
	logic     arst_n    = 1'b0;
	logic     req_valid = 1'b0;
	logic     req_stall;
	krt_req_t req       = '0;
	logic     rsp_valid;
	logic     rsp_stall = 1'b0;
	krt_rsp_t rsp;

	// expectation typed in the table, carried next to the request beat
	bit       req_exact = 1'b0;
	krt_rsp_t req_typed = '0;

	// mirror of the stored records
	krt_rec_t    book [DEPTH];
	int          book_count = 0;
	krt_rsp_t    due_rsps [$];
	script_row_t script [$];
	int          mismatches = 0;
	int          cycle_count = 0;

	// traffic shaping
	int send_idle_pct = 0;
	int stall_pct     = 0;
	int hold_ticket   = 0;
	int hold_seen     = 0;
	int hold_left     = 0;

	logic [15:0]  key_pool  [KEY_POOL];
	logic [159:0] name_pool [NAME_POOL];

	keyed_record_table uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	// 2 ns clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// c-string compare of two 20-byte names, byte 0 in the low bits
	function automatic bit names_match(input logic [159:0] a, input logic [159:0] b);
		int k;
		for (k = 0; k < NAME_B; k++) begin
			if (a[8*k +: 8] != b[8*k +: 8]) return 1'b0;
			if (a[8*k +: 8] == 8'h00) return 1'b1;
		end
		return 1'b1;
	endfunction

	// index of the first record holding this id, or -1
	function automatic int first_with_id(input logic [15:0] id);
		int k;
		for (k = 0; k < book_count; k++)
			if (book[k].id == id) return k;
		return -1;
	endfunction

	// apply one request to the mirror and return the response it gives
	function automatic krt_rsp_t table_apply(input krt_req_t r);
		krt_rsp_t o;
		int hit;
		int k;
		o = '0;
		o.status = ST_NONE;
		hit = -1;
		case (r.func)
			FN_INSERT: begin
				if (book_count >= DEPTH) begin
					o.status = ST_FULL;
				end else begin
					book[book_count] = '{id: r.student_id, name_lo: r.name_word0,
						name_mid: r.name_word1, name_hi: r.name_word2,
						age: r.age_value, score: r.score_value};
					book_count++;
					o.status = ST_DONE;
				end
			end
			FN_DELETE: begin
				k = first_with_id(r.student_id);
				if (k >= 0) begin
					for (; k + 1 < book_count; k++) book[k] = book[k + 1];
					book_count--;
					o.status = ST_DONE;
				end
			end
			FN_FIND_ID: begin
				hit = first_with_id(r.student_id);
			end
			FN_FIND_NAME: begin
				for (k = 0; k < book_count && hit < 0; k++)
					if (names_match({book[k].name_hi, book[k].name_mid, book[k].name_lo},
							{r.name_word2, r.name_word1, r.name_word0}))
						hit = k;
			end
			FN_UPDATE: begin
				k = first_with_id(r.student_id);
				if (k >= 0) begin
					book[k].score = r.score_value;
					o.status = ST_DONE;
				end
			end
			default: begin
			end
		endcase
		if (hit >= 0) begin
			o.status      = ST_DONE;
			o.found_id    = book[hit].id;
			o.found_name0 = book[hit].name_lo;
			o.found_name1 = book[hit].name_mid;
			o.found_name2 = book[hit].name_hi;
			o.found_age   = book[hit].age;
			o.found_score = book[hit].score;
		end
		return o;
	endfunction

	function automatic void check_field(input string field, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", field, want, got);
			mismatches++;
		end
	endfunction

	function automatic krt_rsp_t plain(input krt_status_e s);
		krt_rsp_t o;
		o = '0;
		o.status = s;
		return o;
	endfunction

	// name bytes in string order, zero padded
	function automatic logic [159:0] name_of(input string s);
		logic [159:0] nm;
		int k;
		nm = '0;
		for (k = 0; k < s.len() && k < NAME_B; k++) nm[8*k +: 8] = s[k];
		return nm;
	endfunction

	// random length name, sometimes with junk after the terminator
	function automatic logic [159:0] random_name();
		logic [159:0] nm;
		int len;
		int k;
		bit junk;
		nm = '0;
		len = $urandom_range(0, NAME_B);
		junk = ($urandom_range(4) == 0);
		for (k = 0; k < NAME_B; k++) begin
			if (k < len) nm[8*k +: 8] = 8'($urandom_range(1, 255));
			else if (k > len && junk) nm[8*k +: 8] = 8'($urandom);
		end
		return nm;
	endfunction

	// an id that is stored, from the pool, or anything
	function automatic logic [15:0] random_key(input int stored_pct);
		int roll;
		roll = $urandom_range(99);
		if (book_count != 0 && roll < stored_pct) return book[$urandom_range(book_count - 1)].id;
		if (roll < stored_pct + 20) return key_pool[$urandom_range(KEY_POOL - 1)];
		return 16'($urandom);
	endfunction

	// random request, mostly aimed at what the table currently holds
	function automatic krt_req_t random_request();
		krt_req_t r;
		logic [159:0] nm;
		int ins_w;
		int roll;
		int k;
		bit past_end;
		ins_w = (book_count == DEPTH) ? 10 : 38;
		roll = $urandom_range(ins_w + 22 + 15 + 13 + 9 + 3 - 1);
		r.student_id  = random_key(60);
		r.age_value   = 16'($urandom);
		r.score_value = 16'($urandom);
		nm = random_name();
		if (roll < ins_w) begin
			r.func = FN_INSERT;
			r.student_id = random_key(15);
			if ($urandom_range(99) < 55) nm = name_pool[$urandom_range(NAME_POOL - 1)];
		end else if (roll < ins_w + 22) begin
			r.func = FN_DELETE;
		end else if (roll < ins_w + 37) begin
			r.func = FN_FIND_ID;
		end else if (roll < ins_w + 50) begin
			r.func = FN_FIND_NAME;
			roll = $urandom_range(99);
			if (book_count != 0 && roll < 45) begin
				k = $urandom_range(book_count - 1);
				nm = {book[k].name_hi, book[k].name_mid, book[k].name_lo};
				// same string, different bytes after the terminator
				if ($urandom_range(1)) begin
					past_end = 1'b0;
					for (k = 0; k < NAME_B; k++) begin
						if (past_end) nm[8*k +: 8] = 8'($urandom);
						else if (nm[8*k +: 8] == 8'h00) past_end = 1'b1;
					end
				end
			end else if (roll < 70) begin
				nm = name_pool[$urandom_range(NAME_POOL - 1)];
			end
		end else if (roll < ins_w + 59) begin
			r.func = FN_UPDATE;
		end else begin
			r.func = 3'($urandom_range(FN_SPARE_LO, FN_SPARE_HI));
		end
		{r.name_word2, r.name_word1, r.name_word0} = nm;
		return r;
	endfunction

	function automatic void add_step(input logic [2:0] f, input logic [15:0] id,
			input logic [159:0] nm, input logic [15:0] age, input logic [15:0] score,
			input int reps, input bit exact, input krt_rsp_t want);
		script_row_t s;
		s.req.func        = f;
		s.req.student_id  = id;
		{s.req.name_word2, s.req.name_word1, s.req.name_word0} = nm;
		s.req.age_value   = age;
		s.req.score_value = score;
		s.reps  = reps;
		s.exact = exact;
		s.want  = want;
		script.push_back(s);
	endfunction

	// present one request beat and hold it until it is taken
	task automatic offer(input krt_req_t r, input bit exact, input krt_rsp_t want);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= r;
		req_exact <= exact;
		req_typed <= want;
		@(negedge clk);
		while (req_stall) @(negedge clk);
		@(posedge clk);
	endtask

	// response side: long hold-off on request, otherwise random stalls
	always @(posedge clk) begin
		if (hold_ticket != hold_seen) begin
			hold_seen <= hold_ticket;
			hold_left <= HOLD_CYCLES;
			rsp_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// accepted request beat: predict its response
	always @(posedge clk) begin
		krt_rsp_t guess;
		if (arst_n && req_valid && !req_stall) begin
			guess = table_apply(req);
			due_rsps.push_back(req_exact ? req_typed : guess);
		end
	end

	// accepted response beat: compare with the oldest prediction
	always @(posedge clk) begin
		krt_rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (due_rsps.size() == 0) begin
				$error("response beat with no request outstanding");
				mismatches++;
			end else begin
				want = due_rsps.pop_front();
				check_field("status", want.status, rsp.status);
				check_field("found_id", want.found_id, rsp.found_id);
				check_field("found_name0", want.found_name0, rsp.found_name0);
				check_field("found_name1", want.found_name1, rsp.found_name1);
				check_field("found_name2", want.found_name2, rsp.found_name2);
				check_field("found_age", want.found_age, rsp.found_age);
				check_field("found_score", want.found_score, rsp.found_score);
			end
		end
	end

	initial begin
		krt_rsp_t none_rsp;
		krt_rsp_t done_rsp;
		krt_rsp_t ones_hit;
		krt_req_t r;
		int i;
		int n;
		int p;

		none_rsp = plain(ST_NONE);
		done_rsp = plain(ST_DONE);
		ones_hit = '1;
		ones_hit.status = ST_DONE;

		key_pool[0] = 16'h0000;
		key_pool[1] = 16'hFFFF;
		for (i = 2; i < KEY_POOL; i++) key_pool[i] = 16'($urandom);
		for (i = 0; i < NAME_POOL; i++) name_pool[i] = random_name();

		// empty table, then extremes, full, duplicates and name matching
		add_step(FN_FIND_ID, 16'h0000, '0, 16'h0, 16'h0, 1, 1, none_rsp);
		add_step(FN_DELETE, 16'hFFFF, '0, 16'h0, 16'h0, 1, 1, none_rsp);
		add_step(FN_UPDATE, 16'h0000, '0, 16'h0, 16'hFFFF, 1, 1, none_rsp);
		add_step(FN_FIND_NAME, 16'h0000, '0, 16'h0, 16'h0, 1, 1, none_rsp);
		add_step(FN_SPARE_HI, 16'h0000, '0, 16'h0, 16'h0, 1, 1, none_rsp);
		add_step(FN_INSERT, 16'h0000, '0, 16'h0000, 16'h0000, 1, 1, done_rsp);
		add_step(FN_INSERT, 16'hFFFF, '1, 16'hFFFF, 16'hFFFF, 1, 1, done_rsp);
		add_step(FN_INSERT, 16'h1000, name_of("Filler record"), 16'h0055, 16'h00AA,
			DEPTH - 2, 0, none_rsp);
		add_step(FN_INSERT, 16'h2222, name_of("One too many"), 16'h1, 16'h1, 1, 1,
			plain(ST_FULL));
		add_step(FN_FIND_ID, 16'hFFFF, '0, 16'h0, 16'h0, 1, 1, ones_hit);
		add_step(FN_FIND_NAME, 16'h0000, '1, 16'h0, 16'h0, 1, 1, ones_hit);
		add_step(FN_DELETE, 16'h0000, '0, 16'h0, 16'h0, 1, 1, done_rsp);
		add_step(FN_INSERT, 16'hFFFF, name_of("Al") | (160'hC3 << 72), 16'h0021,
			16'h0042, 1, 1, done_rsp);
		add_step(FN_FIND_NAME, 16'h0000, name_of("Al") | (160'h7E << 120), 16'h0,
			16'h0, 1, 0, none_rsp);
		add_step(FN_FIND_NAME, 16'h0000, name_of("Alx"), 16'h0, 16'h0, 1, 0, none_rsp);
		add_step(FN_UPDATE, 16'hFFFF, '0, 16'h0, 16'h1234, 1, 1, done_rsp);
		add_step(FN_FIND_ID, 16'hFFFF, '0, 16'h0, 16'h0, 1, 0, none_rsp);
		add_step(FN_DELETE, 16'hFFFF, '0, 16'h0, 16'h0, 1, 1, done_rsp);
		add_step(FN_FIND_ID, 16'hFFFF, '0, 16'h0, 16'h0, 1, 0, none_rsp);
		add_step(FN_DELETE, 16'h1007, '0, 16'h0, 16'h0, 1, 1, done_rsp);
		add_step(FN_FIND_ID, 16'h1007, '0, 16'h0, 16'h0, 1, 1, none_rsp);
		add_step(FN_SPARE_LO, 16'h100D, '0, 16'h0, 16'h0, 1, 1, none_rsp);
		add_step(FN_SPARE_MID, 16'h100D, '0, 16'h0, 16'h0, 1, 1, none_rsp);
		add_step(FN_UPDATE, 16'h100D, '0, 16'h0, 16'h0000, 1, 0, none_rsp);
		add_step(FN_DELETE, 16'hFFFF, '0, 16'h0, 16'h0, 1, 1, done_rsp);

		// reset
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		send_idle_pct = 29;
		stall_pct     = 29;
		foreach (script[i]) begin
			for (n = 0; n < script[i].reps; n++) begin
				r = script[i].req;
				r.student_id = r.student_id + 16'(n);
				offer(r, script[i].exact, script[i].want);
			end
		end

		// random traffic under changing flow control
		for (p = 0; p < 5; p++) begin
			case (p)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 86; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 86; end
				3: begin send_idle_pct = 29; stall_pct = 29; end
				default: begin
					// back-pressure: receiver holds off while requests keep coming
					send_idle_pct = 0;
					stall_pct     = 0;
					hold_ticket++;
				end
			endcase
			for (n = 0; n < PHASE_ITEMS; n++) offer(random_request(), 1'b0, none_rsp);
		end
		req_valid <= 1'b0;

		// drain
		while (due_rsps.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && due_rsps.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
